// ===== rtl/core/rvsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rvsi_pkg
// Shared widths, register codes, reset values and pipeline word types for the
// rotated voxel source index block.
// ----------------------------------------------------------------------------
package rvsi_pkg;

    localparam int IDX_W      = 13;
    localparam int MAT_W      = 16;
    localparam int SPC_W      = 16;
    localparam int MIN_W      = 20;
    localparam int REC_W      = 20;
    localparam int EXT_W      = 13;

    localparam int POS_W      = 31;
    localparam int PROD_W     = MAT_W + POS_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int FLOOR_SH   = 10;
    localparam int ROT_W      = SUM_W - FLOOR_SH;
    localparam int SCL_W      = ROT_W + REC_W + 1;
    localparam int ROUND_SH   = 24;
    localparam int SRC_W      = SCL_W - ROUND_SH + 1;
    localparam int LIN_W      = 3 * EXT_W;
    localparam int OUT_W      = 37;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 60;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INV_ROW_X,
        REG_INV_ROW_Y,
        REG_INV_ROW_Z,
        REG_DEST_SPACING,
        REG_DEST_ORIGIN_MIN,
        REG_SRC_SPACING_RECIP,
        REG_SRC_EXTENT,
        REG_SLICE_MODE
    } rvsi_reg_t;

    localparam logic [3*MAT_W-1:0] RST_INV_ROW_X   = 48'h0000_0000_4000;
    localparam logic [3*MAT_W-1:0] RST_INV_ROW_Y   = 48'h0000_4000_0000;
    localparam logic [3*MAT_W-1:0] RST_INV_ROW_Z   = 48'h4000_0000_0000;
    localparam logic [3*SPC_W-1:0] RST_DEST_SPC    = 48'h0100_0100_0100;
    localparam logic [3*MIN_W-1:0] RST_DEST_MIN    = 60'h0;
    localparam logic [3*REC_W-1:0] RST_SRC_RECIP   = 60'h01000_01000_01000;
    localparam logic [3*EXT_W-1:0] RST_SRC_EXTENT  = {13'd1, 13'd1, 13'd1};

    typedef struct packed {
        logic [2:0][2:0][MAT_W-1:0] inv;
        logic [2:0][SPC_W-1:0]      dspc;
        logic [2:0][MIN_W-1:0]      dmin;
        logic [2:0][REC_W-1:0]      recip;
        logic [2:0][EXT_W-1:0]      extent;
        logic                       slice_mode;
    } rvsi_cfg_t;

    typedef struct packed {
        logic [2:0][SCL_W-1:0] scaled;
        logic [IDX_W-1:0]      plane;
        logic                  dest_oob;
    } rvsi_scl_t;

endpackage

// ===== rtl/core/rotated_voxel_source_index.sv =====
// ----------------------------------------------------------------------------
// rotated_voxel_source_index
// Nearest-neighbor inverse mapping for a rotated voxel grid.
//
// Input channel (s_): one destination voxel per word (column, row, plane).
// Output channel (m_): one source index per word, plane-major, or all ones
// (-1) when the mapped voxel falls outside the source volume.
// Config channel (cfg_): writes one register per word; cfg_ready is always
// high. Write only while the pipeline is empty.
// Accepts one word per cycle while the receiver takes results; all eight
// register stages advance together on one enable.
// Reset clears all valid bits and loads identity matrix, unit spacings,
// zero origin and a 1x1x1 source. No clearing pass is needed.
// When the receiver stalls the whole pipeline holds and s_ready drops in
// the same cycle; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module rotated_voxel_source_index
    import rvsi_pkg::*;
#(
    parameter int SRC_DIM_MAX  = 4096,
    parameter int DEST_DIM_MAX = 8192
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [IDX_W-1:0]        s_dest_col,
    input  logic [IDX_W-1:0]        s_dest_row,
    input  logic [IDX_W-1:0]        s_dest_plane,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [OUT_W-1:0] m_source_index,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    rvsi_cfg_t             cfg;
    rvsi_scl_t             scl_item;
    logic                  scl_valid;
    logic                  adv;
    logic [2:0][IDX_W-1:0] in_idx;
    logic [OUT_W-1:0]      out_index;

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;
    assign in_idx  = {s_dest_plane, s_dest_row, s_dest_col};

    rvsi_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rvsi_rotate #(
        .DEST_DIM_MAX (DEST_DIM_MAX)
    ) u_rotate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .in_idx    (in_idx),
        .cfg       (cfg),
        .out_valid (scl_valid),
        .out_item  (scl_item)
    );

    rvsi_index #(
        .SRC_DIM_MAX (SRC_DIM_MAX)
    ) u_index (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (scl_valid),
        .in_item   (scl_item),
        .cfg       (cfg),
        .out_valid (m_valid),
        .out_index (out_index)
    );

    assign m_source_index = out_index;

`ifndef SYNTHESIS
    a_stall_from_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without output backpressure");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_index_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (SRC_DIM_MAX <= 4096)) |->
            ((m_source_index == '1) || !m_source_index[OUT_W-1]))
        else $error("source index neither outside marker nor in range");
`endif

endmodule

// ===== rtl/core/rvsi_cfg.sv =====
// ----------------------------------------------------------------------------
// rvsi_cfg
// Configuration register file: decodes register writes and presents the
// fields to the datapath.
// ----------------------------------------------------------------------------
module rvsi_cfg
    import rvsi_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output rvsi_cfg_t             cfg
);

    logic [2:0][3*MAT_W-1:0] inv_reg;
    logic [3*SPC_W-1:0]      dspc_reg;
    logic [3*MIN_W-1:0]      dmin_reg;
    logic [3*REC_W-1:0]      recip_reg;
    logic [3*EXT_W-1:0]      extent_reg;
    logic                    slice_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_reg[0] <= RST_INV_ROW_X;
            inv_reg[1] <= RST_INV_ROW_Y;
            inv_reg[2] <= RST_INV_ROW_Z;
            dspc_reg   <= RST_DEST_SPC;
            dmin_reg   <= RST_DEST_MIN;
            recip_reg  <= RST_SRC_RECIP;
            extent_reg <= RST_SRC_EXTENT;
            slice_reg  <= 1'b0;
        end else if (cfg_valid) begin
            unique case (rvsi_reg_t'(cfg_index))
                REG_INV_ROW_X:         inv_reg[0] <= cfg_data[3*MAT_W-1:0];
                REG_INV_ROW_Y:         inv_reg[1] <= cfg_data[3*MAT_W-1:0];
                REG_INV_ROW_Z:         inv_reg[2] <= cfg_data[3*MAT_W-1:0];
                REG_DEST_SPACING:      dspc_reg   <= cfg_data[3*SPC_W-1:0];
                REG_DEST_ORIGIN_MIN:   dmin_reg   <= cfg_data[3*MIN_W-1:0];
                REG_SRC_SPACING_RECIP: recip_reg  <= cfg_data[3*REC_W-1:0];
                REG_SRC_EXTENT:        extent_reg <= cfg_data[3*EXT_W-1:0];
                REG_SLICE_MODE:        slice_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.inv[0]     = inv_reg[0];
        cfg.inv[1]     = inv_reg[1];
        cfg.inv[2]     = inv_reg[2];
        cfg.dspc       = dspc_reg;
        cfg.dmin       = dmin_reg;
        cfg.recip      = recip_reg;
        cfg.extent     = extent_reg;
        cfg.slice_mode = slice_reg;
    end

endmodule

// ===== rtl/core/rvsi_rotate.sv =====
// ----------------------------------------------------------------------------
// rvsi_rotate
// Four-stage front end: physical position, matrix products, row sums with
// floor to Q.12, and scaling by the reciprocal source spacing.
// ----------------------------------------------------------------------------
module rvsi_rotate
    import rvsi_pkg::*;
#(
    parameter int DEST_DIM_MAX = 8192
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  logic                  in_valid,
    input  logic [2:0][IDX_W-1:0] in_idx,
    input  rvsi_cfg_t             cfg,
    output logic                  out_valid,
    output rvsi_scl_t             out_item
);

    logic [3:0]                 vld_reg;
    logic [IDX_W+SPC_W-1:0]     spc_prod [3];
    logic signed [POS_W-1:0]    pos_next [3];
    logic signed [POS_W-1:0]    pos_reg [3];
    logic                       oob_next;
    logic [IDX_W-1:0]           plane_reg [4];
    logic [3:0]                 oob_reg;
    logic signed [PROD_W-1:0]   mp_reg [3][3];
    logic signed [SUM_W-1:0]    sum_next [3];
    logic signed [ROT_W-1:0]    rot_reg [3];
    logic signed [SCL_W-1:0]    scl_reg [3];

    always_comb begin
        oob_next = 1'b0;
        for (int a = 0; a < 3; a++) begin
            spc_prod[a] = in_idx[a] * cfg.dspc[a];
            pos_next[a] = $signed({{(POS_W-IDX_W-SPC_W){1'b0}}, spc_prod[a]})
                        + $signed({{(POS_W-MIN_W){cfg.dmin[a][MIN_W-1]}}, cfg.dmin[a]});
            if (32'(in_idx[a]) >= DEST_DIM_MAX) begin
                oob_next = 1'b1;
            end
        end
        for (int r = 0; r < 3; r++) begin
            sum_next[r] = SUM_W'(mp_reg[r][0]) + SUM_W'(mp_reg[r][1]) + SUM_W'(mp_reg[r][2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            plane_reg[0] <= in_idx[2];
            oob_reg[0]   <= oob_next;
            for (int k = 1; k < 4; k++) begin
                plane_reg[k] <= plane_reg[k-1];
                oob_reg[k]   <= oob_reg[k-1];
            end
            for (int r = 0; r < 3; r++) begin
                pos_reg[r] <= pos_next[r];
                for (int c = 0; c < 3; c++) begin
                    mp_reg[r][c] <= $signed(cfg.inv[r][c]) * pos_reg[c];
                end
                rot_reg[r] <= sum_next[r][SUM_W-1:FLOOR_SH];
                scl_reg[r] <= rot_reg[r] * $signed({1'b0, cfg.recip[r]});
            end
        end
    end

    always_comb begin
        out_valid = vld_reg[3];
        for (int r = 0; r < 3; r++) begin
            out_item.scaled[r] = scl_reg[r];
        end
        out_item.plane    = plane_reg[3];
        out_item.dest_oob = oob_reg[3];
    end

endmodule

// ===== rtl/core/rvsi_index.sv =====
// ----------------------------------------------------------------------------
// rvsi_index
// Four-stage back end: round half to even, range check against the source
// extent, and plane-major linear index with the outside marker.
// ----------------------------------------------------------------------------
module rvsi_index
    import rvsi_pkg::*;
#(
    parameter int SRC_DIM_MAX = 4096
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic             in_valid,
    input  rvsi_scl_t        in_item,
    input  rvsi_cfg_t        cfg,
    output logic             out_valid,
    output logic [OUT_W-1:0] out_index
);

    localparam logic [ROUND_SH-1:0] ROUND_HALF = ROUND_SH'(1) << (ROUND_SH - 1);

    logic [2:0]                 vld_reg;
    logic                       out_valid_reg;
    logic [EXT_W-1:0]           ext_c [3];
    logic [SCL_W-ROUND_SH-1:0]  fl [3];
    logic [ROUND_SH-1:0]        fr [3];
    logic                       rnd_inc [3];
    logic [SRC_W-1:0]           src_next [3];
    logic [SRC_W-1:0]           src_reg [3];
    logic                       oob5_reg;
    logic [2:0]                 in_rng;
    logic                       inside6_next;
    logic                       inside6_reg;
    logic [EXT_W-1:0]           coord_reg [3];
    logic [2*EXT_W-1:0]         xy_reg;
    logic [LIN_W-1:0]           zterm_reg;
    logic [2*EXT_W:0]           yterm_reg;
    logic                       inside7_reg;
    logic [LIN_W-1:0]           lin;
    logic [OUT_W-1:0]           out_reg;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            ext_c[a] = (32'(cfg.extent[a]) > SRC_DIM_MAX) ? EXT_W'(SRC_DIM_MAX)
                                                           : cfg.extent[a];
            fl[a]       = in_item.scaled[a][SCL_W-1:ROUND_SH];
            fr[a]       = in_item.scaled[a][ROUND_SH-1:0];
            rnd_inc[a]  = (fr[a] > ROUND_HALF) || ((fr[a] == ROUND_HALF) && fl[a][0]);
            src_next[a] = {fl[a][SCL_W-ROUND_SH-1], fl[a]} + SRC_W'(rnd_inc[a]);
            in_rng[a]   = !src_reg[a][SRC_W-1] && (src_reg[a] < SRC_W'(ext_c[a]));
        end
        if (cfg.slice_mode) begin
            src_next[2] = SRC_W'(in_item.plane);
        end
        inside6_next = (&in_rng) && !oob5_reg;
        lin          = zterm_reg + LIN_W'(yterm_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg       <= {vld_reg[1:0], in_valid};
            out_valid_reg <= vld_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int a = 0; a < 3; a++) begin
                src_reg[a]   <= src_next[a];
                coord_reg[a] <= src_reg[a][EXT_W-1:0];
            end
            oob5_reg    <= in_item.dest_oob;
            inside6_reg <= inside6_next;
            xy_reg      <= ext_c[0] * ext_c[1];
            zterm_reg   <= xy_reg * coord_reg[2];
            yterm_reg   <= ext_c[0] * coord_reg[1] + (2*EXT_W+1)'(coord_reg[0]);
            inside7_reg <= inside6_reg;
            out_reg     <= inside7_reg ? lin[OUT_W-1:0] : '1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_reg;

endmodule

// ===== bench/source_index_board_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// source_index_board_pkg
// Scoreboard for the rotated voxel source index block. It keeps its own copy
// of the register file, computes the expected source index of every
// destination voxel that the block accepts, and checks the result words in
// order against those predictions.
// ----------------------------------------------------------------------------
package source_index_board_pkg;

    import rvsi_pkg::*;

    typedef struct {
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] plane;
        logic [OUT_W-1:0] index;
    } voxel_lookup_t;

    class source_index_board;

        localparam longint SRC_DIM_MAX = 4096;
        localparam longint ROUND_HALF  = 64'sd1 <<< (ROUND_SH - 1);

        rvsi_cfg_t     regs;
        voxel_lookup_t lookups[$];
        int            errors;

        function new();
            regs.inv[0]     = 48'h0000_0000_4000;
            regs.inv[1]     = 48'h0000_4000_0000;
            regs.inv[2]     = 48'h4000_0000_0000;
            regs.dspc       = 48'h0100_0100_0100;
            regs.dmin       = '0;
            regs.recip      = 60'h01000_01000_01000;
            regs.extent     = {13'd1, 13'd1, 13'd1};
            regs.slice_mode = 1'b0;
            errors          = 0;
        endfunction

        function void write_reg(rvsi_reg_t sel, logic [CFG_DATA_W-1:0] data);
            case (sel)
                REG_INV_ROW_X:         regs.inv[0]     = data[3*MAT_W-1:0];
                REG_INV_ROW_Y:         regs.inv[1]     = data[3*MAT_W-1:0];
                REG_INV_ROW_Z:         regs.inv[2]     = data[3*MAT_W-1:0];
                REG_DEST_SPACING:      regs.dspc       = data[3*SPC_W-1:0];
                REG_DEST_ORIGIN_MIN:   regs.dmin       = data[3*MIN_W-1:0];
                REG_SRC_SPACING_RECIP: regs.recip      = data[3*REC_W-1:0];
                REG_SRC_EXTENT:        regs.extent     = data[3*EXT_W-1:0];
                REG_SLICE_MODE:        regs.slice_mode = data[0];
                default: ;
            endcase
        endfunction

        function logic [OUT_W-1:0] source_of(logic [IDX_W-1:0] col, logic [IDX_W-1:0] row,
                                             logic [IDX_W-1:0] plane);
            logic [IDX_W-1:0] idx [3];
            longint           ext [3];
            longint           pos [3];
            longint           src [3];
            longint           acc;
            longint           mag;
            longint           whole;
            longint           rem;
            bit               neg;
            int               a;
            int               c;
            idx[0] = col;
            idx[1] = row;
            idx[2] = plane;
            for (a = 0; a < 3; a++) begin
                ext[a] = longint'(regs.extent[a]);
                if (ext[a] > SRC_DIM_MAX) ext[a] = SRC_DIM_MAX;
                pos[a] = longint'(idx[a]) * longint'(regs.dspc[a])
                       + longint'($signed(regs.dmin[a]));
            end
            for (a = 0; a < 3; a++) begin
                acc = 0;
                for (c = 0; c < 3; c++)
                    acc += longint'($signed(regs.inv[a][c])) * pos[c];
                // floor to Q.12, scale, then round half to even on the magnitude
                acc   = (acc >>> FLOOR_SH) * longint'(regs.recip[a]);
                neg   = acc < 0;
                mag   = neg ? -acc : acc;
                whole = mag >>> ROUND_SH;
                rem   = mag & ((64'sd1 <<< ROUND_SH) - 1);
                if (rem > ROUND_HALF || (rem == ROUND_HALF && whole[0])) whole++;
                src[a] = neg ? -whole : whole;
            end
            if (regs.slice_mode) src[2] = longint'(idx[2]);
            for (a = 0; a < 3; a++)
                if (src[a] < 0 || src[a] >= ext[a]) return '1;
            return OUT_W'(ext[0] * ext[1] * src[2] + ext[0] * src[1] + src[0]);
        endfunction

        function void note_voxel(logic [IDX_W-1:0] col, logic [IDX_W-1:0] row,
                                 logic [IDX_W-1:0] plane);
            voxel_lookup_t lk;
            lk.col   = col;
            lk.row   = row;
            lk.plane = plane;
            lk.index = source_of(col, row, plane);
            lookups  = {lookups, lk};
        endfunction

        function int pending();
            return lookups.size();
        endfunction

        task report_mismatch(string what, logic [OUT_W-1:0] got, voxel_lookup_t lk);
            $display("mismatch (%s): voxel %0d,%0d,%0d got %0d expected %0d", what,
                     lk.col, lk.row, lk.plane, $signed(got), $signed(lk.index));
            errors++;
        endtask

        task check_index(logic [OUT_W-1:0] got);
            voxel_lookup_t lk;
            if (lookups.size() == 0) begin
                lk = '{default: '0};
                report_mismatch("no word outstanding", got, lk);
            end else begin
                lk = lookups.pop_front();
                if (got !== lk.index) report_mismatch("source_index", got, lk);
            end
        endtask

    endclass

endpackage

// ===== bench/tb_rotated_voxel_source_index.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rotated_voxel_source_index
// Self-checking bench for the rotated voxel source index block. Register
// settings change between phases while the pipeline is empty: reset values,
// half-voxel spacing for rounding, mirrored axes, random rotations, slice
// mode, clamped wide extents and all-zero / all-one registers. Voxel words
// are drawn mostly near the source volume, some over the full index range.
// Both sides idle at random; the receiver also holds off for long stretches.
// ----------------------------------------------------------------------------
module tb_rotated_voxel_source_index;

    import rvsi_pkg::*;
    import source_index_board_pkg::*;

    localparam int LATENCY         = 8;
    localparam int HOLD_CYCLES     = 80;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int ITEMS_PER_PHASE = 176;
    localparam int IDX_MAX         = (1 << IDX_W) - 1;

    typedef enum int {
        PH_HALF_STEP,
        PH_MIRROR,
        PH_TURNED,
        PH_SLICE,
        PH_WIDE,
        PH_ALL_ONES,
        PH_ALL_ZERO
    } phase_kind_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic [IDX_W-1:0]        s_dest_col;
    logic [IDX_W-1:0]        s_dest_row;
    logic [IDX_W-1:0]        s_dest_plane;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [OUT_W-1:0] m_source_index;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    source_index_board board = new();
    bit                burst;
    int                reach [3];
    int                rx_count;

    rotated_voxel_source_index i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_dest_col     (s_dest_col),
        .s_dest_row     (s_dest_row),
        .s_dest_plane   (s_dest_plane),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_source_index (m_source_index),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    task automatic send_voxel(input int col, input int row, input int plane);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 5);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_dest_col   <= IDX_W'(col);
        s_dest_row   <= IDX_W'(row);
        s_dest_plane <= IDX_W'(plane);
        do @(posedge aclk); while (!s_ready);
        board.note_voxel(IDX_W'(col), IDX_W'(row), IDX_W'(plane));
    endtask

    task automatic write_cfg(input rvsi_reg_t sel, input logic [CFG_DATA_W-1:0] value,
                             input int width);
        logic [CFG_DATA_W-1:0] keep;
        logic [CFG_DATA_W-1:0] data;
        keep = (CFG_DATA_W'(1) << width) - 1;
        data = (value & keep) | (CFG_DATA_W'({$urandom, $urandom}) & ~keep);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        board.write_reg(sel, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // drop valid and hold until the pipeline is empty
    task automatic drain_pipeline();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic program_phase(input phase_kind_t kind);
        logic [2:0][2:0][MAT_W-1:0] mat;
        logic [2:0][SPC_W-1:0]      spc;
        logic [2:0][MIN_W-1:0]      omin;
        logic [2:0][REC_W-1:0]      rec;
        logic [2:0][EXT_W-1:0]      ext;
        logic                       slice;
        int                         a;
        int                         c;
        int                         eff;
        for (a = 0; a < 3; a++) begin
            for (c = 0; c < 3; c++) mat[a][c] = (a == c) ? 16'h4000 : 16'h0000;
            spc[a]  = 16'h0100;
            omin[a] = '0;
            rec[a]  = 20'h01000;
            ext[a]  = EXT_W'($urandom_range(1, 40));
        end
        slice = 1'b0;
        case (kind)
            PH_HALF_STEP: begin
                spc = {3{16'h0080}};
                ext = {13'd4, 13'd8, 13'd16};
            end
            PH_MIRROR: begin
                mat[0][0] = 16'hC000;
                mat[1][1] = 16'hC000;
                omin[0]   = MIN_W'(256 * (1 - int'(ext[0])));
                omin[1]   = MIN_W'(256 * (1 - int'(ext[1])));
            end
            PH_TURNED: begin
                for (a = 0; a < 3; a++) begin
                    for (c = 0; c < 3; c++) mat[a][c] = MAT_W'($urandom_range(0, 32768) - 16384);
                    spc[a]  = SPC_W'($urandom_range(64, 512));
                    omin[a] = MIN_W'(int'($urandom_range(0, 4096)) - 2048);
                    rec[a]  = ($urandom_range(0, 7) == 0) ? '0 : REC_W'($urandom_range(2048, 8192));
                    ext[a]  = EXT_W'($urandom_range(0, 48));
                end
                slice = 1'($urandom_range(0, 1));
            end
            PH_SLICE: begin
                mat[2]    = (3*MAT_W)'({$urandom, $urandom});
                mat[0][1] = MAT_W'($urandom_range(0, 4096) - 2048);
                mat[1][0] = MAT_W'($urandom_range(0, 4096) - 2048);
                rec[0]    = REC_W'($urandom_range(3000, 5000));
                rec[1]    = REC_W'($urandom_range(3000, 5000));
                slice     = 1'b1;
            end
            PH_WIDE: begin
                omin[0] = MIN_W'($urandom);
                ext[0]  = EXT_W'($urandom_range(4097, IDX_MAX));
                ext[1]  = EXT_W'($urandom_range(1, 3));
                ext[2]  = EXT_W'($urandom_range(1, 2));
            end
            PH_ALL_ONES: begin
                mat   = '1;
                spc   = '1;
                omin  = '1;
                rec   = '1;
                ext   = '1;
                slice = 1'b1;
            end
            PH_ALL_ZERO: begin
                mat  = '0;
                spc  = '0;
                omin = '0;
                rec  = '0;
                ext  = '0;
            end
            default: ;
        endcase
        for (a = 0; a < 3; a++) begin
            eff      = (int'(ext[a]) > 4096) ? 4096 : int'(ext[a]);
            reach[a] = (2 * eff + 4 > IDX_MAX) ? IDX_MAX : 2 * eff + 4;
        end
        write_cfg(REG_INV_ROW_X,         CFG_DATA_W'(mat[0]), 3 * MAT_W);
        write_cfg(REG_INV_ROW_Y,         CFG_DATA_W'(mat[1]), 3 * MAT_W);
        write_cfg(REG_INV_ROW_Z,         CFG_DATA_W'(mat[2]), 3 * MAT_W);
        write_cfg(REG_DEST_SPACING,      CFG_DATA_W'(spc),    3 * SPC_W);
        write_cfg(REG_DEST_ORIGIN_MIN,   CFG_DATA_W'(omin),   3 * MIN_W);
        write_cfg(REG_SRC_SPACING_RECIP, CFG_DATA_W'(rec),    3 * REC_W);
        write_cfg(REG_SRC_EXTENT,        CFG_DATA_W'(ext),    3 * EXT_W);
        write_cfg(REG_SLICE_MODE,        CFG_DATA_W'(slice),  1);
    endtask

    // result side: random stalls plus two long hold-offs
    initial begin
        int gap;
        m_ready  = 1'b0;
        rx_count = 0;
        wait (aresetn === 1'b1);
        forever begin
            gap = burst ? 0 : $urandom_range(0, 5);
            if (rx_count == 100 || rx_count == 900) gap = HOLD_CYCLES;
            @(negedge aclk);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            board.check_index(m_source_index);
            rx_count++;
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        phase_kind_t plan [11];
        int          ph;
        int          n;
        int          a;
        int          v [3];
        bit          wide;
        plan = '{PH_MIRROR, PH_TURNED, PH_SLICE, PH_ALL_ONES, PH_TURNED, PH_ALL_ZERO,
                 PH_WIDE, PH_MIRROR, PH_TURNED, PH_SLICE, PH_TURNED};
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_dest_col   = '0;
        s_dest_row   = '0;
        s_dest_plane = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        burst        = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset registers: only the origin voxel lies inside
        send_voxel(0, 0, 0);
        send_voxel(1, 0, 0);
        send_voxel(0, 1, 0);
        send_voxel(0, 0, 1);
        send_voxel(IDX_MAX, IDX_MAX, IDX_MAX);
        send_voxel(13'h1555, 13'h0AAA, 13'h1555);
        send_voxel(13'h0AAA, 13'h1555, 13'h0AAA);
        drain_pipeline();

        // half-voxel spacing: ties round to even, edges of a 16x8x4 source
        program_phase(PH_HALF_STEP);
        send_voxel(1, 1, 1);
        send_voxel(3, 3, 3);
        send_voxel(5, 0, 0);
        send_voxel(30, 14, 6);
        send_voxel(31, 0, 0);
        send_voxel(0, 15, 0);
        send_voxel(0, 14, 7);
        send_voxel(0, 0, 6);
        send_voxel(0, 0, IDX_MAX);
        drain_pipeline();

        for (ph = 0; ph < 11; ph++) begin
            program_phase(plan[ph]);
            burst = (ph % 4 == 3);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                wide = ($urandom_range(0, 4) == 0);
                for (a = 0; a < 3; a++)
                    v[a] = wide ? $urandom_range(0, IDX_MAX) : $urandom_range(0, reach[a]);
                send_voxel(v[0], v[1], v[2]);
            end
            drain_pipeline();
            burst = 1'b0;
        end

        repeat (LATENCY) @(posedge aclk);
        if (board.errors == 0 && board.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
